>>> rtl/cursor_sprite_overlay_palette_core_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the cursor overlay core
// Clocked property wrappers shared by the RTL checks.
// -----------------------------------------------------------------------------
`ifndef CURSOR_SPRITE_OVERLAY_PALETTE_CORE_MACROS_SVH
`define CURSOR_SPRITE_OVERLAY_PALETTE_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define CSOP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CSOP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/csop_pkg.sv
// -----------------------------------------------------------------------------
// csop_pkg
// Types, register codes, palette and sprite constants of the cursor overlay.
// -----------------------------------------------------------------------------
package csop_pkg;

   localparam int unsigned XW   = 12;  // pixel column / row width
   localparam int unsigned IDXW = 4;   // palette index width
   localparam int unsigned SWW  = 13;  // screen width register width
   localparam int unsigned POSW = 5;   // sprite column / row width

   localparam logic [SWW-1:0] MaxScreenWidth = 13'd4096;
   localparam logic [SWW-1:0] ResetScreenWidth = 13'd640;

   // sprite geometry
   localparam logic [POSW-1:0] SmallW = 5'd12;
   localparam logic [POSW-1:0] SmallH = 5'd16;
   localparam logic [POSW-1:0] LargeW = 5'd18;
   localparam logic [POSW-1:0] LargeH = 5'd24;
   localparam logic [POSW-1:0] SmallFootRow = 5'd10;
   localparam logic [POSW-1:0] SmallHeelRow = 5'd11;
   localparam logic [POSW-1:0] SmallMirror = 5'd15;
   localparam logic [POSW-1:0] LargeFootRow = 5'd16;
   localparam logic [POSW-1:0] LargeHeelRow = 5'd17;
   localparam logic [POSW-1:0] LargeMirror = 5'd23;
   localparam logic [POSW-1:0] SmallFootFill = 5'd4;
   localparam logic [POSW-1:0] SmallHeelFill = 5'd3;
   localparam logic [POSW-1:0] LargeFootFill = 5'd6;
   localparam logic [POSW-1:0] LargeHeelFill = 5'd5;
   localparam logic [POSW-1:0] TipWidth = 5'd3;

   // palette indexes painted by the sprite
   localparam logic [IDXW-1:0] SprIdxBlack = 4'd0;
   localparam logic [IDXW-1:0] SprIdxFill  = 4'd7;
   localparam logic [IDXW-1:0] SprIdxEdge  = 4'd8;

   typedef enum logic [2:0] {
      CSR_CURSOR_LEFT  = 3'd0,
      CSR_CURSOR_TOP   = 3'd1,
      CSR_CURSOR_LARGE = 3'd2,
      CSR_SCREEN_WIDTH = 3'd3,
      CSR_PIXEL_FORMAT = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      FMT_INDEX = 2'd0,
      FMT_RGB   = 2'd1,
      FMT_ARGB  = 2'd2,
      FMT_ARGB_ALT = 2'd3
   } pixel_format_type;

   typedef enum logic [1:0] {
      SPR_BLACK,
      SPR_FILL,
      SPR_EDGE,
      SPR_CLEAR
   } sprite_code_type;

   typedef enum logic [1:0] {
      ROW_BODY,
      ROW_FOOT,
      ROW_HEEL
   } row_kind_type;

   function automatic logic [31:0] palette_lookup(input logic [IDXW-1:0] idx);
      logic [31:0] argb;
      unique case (idx)
         4'd0:    argb = 32'hFF000000;
         4'd1:    argb = 32'hFFFFFFFF;
         4'd2:    argb = 32'hFF181014;
         4'd3:    argb = 32'hFF20181C;
         4'd4:    argb = 32'hFF30282C;
         4'd5:    argb = 32'hFF105070;
         4'd6:    argb = 32'hFF307090;
         4'd7:    argb = 32'hFFB05070;
         4'd8:    argb = 32'hFFF898B8;
         4'd9:    argb = 32'hFF80787C;
         4'd10:   argb = 32'hFFFFFFFF;
         default: argb = 32'h00000000;
      endcase
      return argb;
   endfunction

endpackage

>>> rtl/cursor_sprite_overlay_palette_core.sv
// -----------------------------------------------------------------------------
// cursor_sprite_overlay_palette_core
// Hardware arrow cursor overlay and palette conversion on a pixel stream.
// -----------------------------------------------------------------------------
// Usage:
//  - req_* carries one screen pixel per request: column, row and the palette
//    index already painted there. rsp_* returns the final pixel in the
//    selected format, with rsp_tuser set when the cursor covered the pixel.
//  - csr_* writes the cursor position, sprite size, screen width and output
//    format. csr_ready is always high; write only while no request is in
//    flight.
//  - Four register stages lie between request accept and rsp_tvalid:
//    offset subtract, box test and row decode, column decode and sprite merge,
//    palette/format. Throughput is one request per cycle while rsp_tready is high.
//  - Every stage holds its own valid bit and loads whenever it is empty or
//    its successor moves, so bubbles close up and new requests keep entering
//    while a finished pixel waits on a stalled rsp_tready. With all four
//    stages full and rsp_tready low, req_tready drops; nothing is lost.
//  - Reset (synchronous) empties the pipeline and loads the register reset
//    values: cursor at 0,0, small sprite, 640 pixel screen, ARGB output.
// -----------------------------------------------------------------------------
`include "cursor_sprite_overlay_palette_core_macros.svh"

module cursor_sprite_overlay_palette_core (
   input  logic        clock,
   input  logic        reset,
   // request: [11:0] pixel_x, [23:12] pixel_y, [27:24] background_index, rest 0
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // response: [31:0] pixel_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // response: [0] cursor_hit
   output logic [0:0]  rsp_tuser,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [csop_pkg::SWW-1:0] csr_data
);
   import csop_pkg::*;

   // ---------------------------------------------------------------- registers
   logic [XW-1:0]    cursor_left_ff, cursor_left_in;
   logic [XW-1:0]    cursor_top_ff, cursor_top_in;
   logic             cursor_large_ff, cursor_large_in;
   logic [SWW-1:0]   screen_width_ff, screen_width_in;
   pixel_format_type pixel_format_ff, pixel_format_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cursor_left_in  = cursor_left_ff;
      cursor_top_in   = cursor_top_ff;
      cursor_large_in = cursor_large_ff;
      screen_width_in = screen_width_ff;
      pixel_format_in = pixel_format_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CURSOR_LEFT:  cursor_left_in  = csr_data[XW-1:0];
            CSR_CURSOR_TOP:   cursor_top_in   = csr_data[XW-1:0];
            CSR_CURSOR_LARGE: cursor_large_in = csr_data[0];
            CSR_SCREEN_WIDTH: screen_width_in = csr_data;
            CSR_PIXEL_FORMAT: pixel_format_in = pixel_format_type'(csr_data[1:0]);
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_left_ff  <= '0;
         cursor_top_ff   <= '0;
         cursor_large_ff <= 1'b0;
         screen_width_ff <= ResetScreenWidth;
         pixel_format_ff <= FMT_ARGB;
      end else begin
         cursor_left_ff  <= cursor_left_in;
         cursor_top_ff   <= cursor_top_in;
         cursor_large_ff <= cursor_large_in;
         screen_width_ff <= screen_width_in;
         pixel_format_ff <= pixel_format_in;
      end
   end

   // ---------------------------------------------------------- stage control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_load, s2_load, s3_load, s4_load;

   // a stage loads when empty or when its contents move on
   assign s4_load = !s4_valid_ff || rsp_tready;
   assign s3_load = !s3_valid_ff || s4_load;
   assign s2_load = !s2_valid_ff || s3_load;
   assign s1_load = !s1_valid_ff || s2_load;

   assign req_tready = s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_load) s1_valid_ff <= req_tvalid;
         if (s2_load) s2_valid_ff <= s1_valid_ff;
         if (s3_load) s3_valid_ff <= s2_valid_ff;
         if (s4_load) s4_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------------------------------------------- stage 1: offsets
   logic [XW-1:0]   px, py;
   logic [IDXW-1:0] bg_idx;
   logic [SWW-1:0]  dx, dy, sw_sat;
   logic            near_in;

   assign px     = req_tdata[XW-1:0];
   assign py     = req_tdata[2*XW-1:XW];
   assign bg_idx = req_tdata[2*XW+IDXW-1:2*XW];

   always_comb begin
      sw_sat = (screen_width_ff > MaxScreenWidth) ? MaxScreenWidth : screen_width_ff;
      dx = {1'b0, px} - {1'b0, cursor_left_ff};
      dy = {1'b0, py} - {1'b0, cursor_top_ff};
      // no borrow, offsets fit a sprite coordinate, column left of the clip
      near_in = !dx[SWW-1] && !dy[SWW-1]
             && (dx[SWW-2:POSW] == '0) && (dy[SWW-2:POSW] == '0)
             && ({1'b0, px} < sw_sat);
   end

   logic [POSW-1:0] s1_col_ff, s1_row_ff;
   logic            s1_near_ff;
   logic [IDXW-1:0] s1_idx_ff;

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_col_ff  <= dx[POSW-1:0];
         s1_row_ff  <= dy[POSW-1:0];
         s1_near_ff <= near_in;
         s1_idx_ff  <= bg_idx;
      end
   end

   // --------------------------------------------- stage 2: box test, row decode
   logic [POSW-1:0] spr_w, spr_h, mirror_row, foot_row, heel_row, row_fold;
   logic            in_box;
   row_kind_type    row_kind;

   always_comb begin
      spr_w      = cursor_large_ff ? LargeW : SmallW;
      spr_h      = cursor_large_ff ? LargeH : SmallH;
      mirror_row = cursor_large_ff ? LargeMirror : SmallMirror;
      foot_row   = cursor_large_ff ? LargeFootRow : SmallFootRow;
      heel_row   = cursor_large_ff ? LargeHeelRow : SmallHeelRow;
      in_box     = s1_near_ff && (s1_col_ff < spr_w) && (s1_row_ff < spr_h);
      row_fold   = s1_row_ff;
      row_kind   = ROW_BODY;
      // lower wing mirrors the upper one below the heel row
      priority if (s1_row_ff == foot_row) begin
         row_kind = ROW_FOOT;
      end else if (s1_row_ff == heel_row) begin
         row_kind = ROW_HEEL;
      end else if (s1_row_ff > heel_row) begin
         row_fold = mirror_row - s1_row_ff;
      end else begin
         row_fold = s1_row_ff;
      end
   end

   logic [POSW-1:0] s2_col_ff, s2_row_ff;
   row_kind_type    s2_kind_ff;
   logic            s2_box_ff, s2_large_ff;
   logic [IDXW-1:0] s2_idx_ff;

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_col_ff   <= s1_col_ff;
         s2_row_ff   <= row_fold;
         s2_kind_ff  <= row_kind;
         s2_box_ff   <= in_box;
         s2_large_ff <= cursor_large_ff;
         s2_idx_ff   <= s1_idx_ff;
      end
   end

   // -------------------------------------- stage 3: column decode and merge
   sprite_code_type code;
   logic [POSW-1:0] foot_fill, heel_fill, last_col;
   logic [IDXW-1:0] merged_idx;
   logic            hit;

   always_comb begin
      foot_fill = s2_large_ff ? LargeFootFill : SmallFootFill;
      heel_fill = s2_large_ff ? LargeHeelFill : SmallHeelFill;
      last_col  = (s2_large_ff ? LargeW : SmallW) - 5'd1;
      code      = SPR_CLEAR;
      unique case (s2_kind_ff)
         ROW_FOOT: begin
            priority if (s2_col_ff == 5'd0)      code = SPR_BLACK;
            else if (s2_col_ff == 5'd1)          code = SPR_EDGE;
            else if (s2_col_ff <= foot_fill)     code = SPR_FILL;
            else if (s2_col_ff < last_col)       code = SPR_EDGE;
            else                                 code = SPR_BLACK;
         end
         ROW_HEEL: begin
            priority if (s2_col_ff == 5'd0)      code = SPR_BLACK;
            else if (s2_col_ff == 5'd1)          code = SPR_EDGE;
            else if (s2_col_ff <= heel_fill)     code = SPR_FILL;
            else if (s2_col_ff == heel_fill + 5'd1) code = SPR_EDGE;
            else                                 code = SPR_BLACK;
         end
         default: begin
            // tip row, then diagonal rows with a two-pixel black rim
            priority if (s2_row_ff == 5'd0)
               code = (s2_col_ff < TipWidth) ? SPR_BLACK : SPR_CLEAR;
            else if (s2_col_ff == 5'd0)                  code = SPR_BLACK;
            else if (s2_col_ff == 5'd1 || s2_col_ff == s2_row_ff) code = SPR_EDGE;
            else if (s2_col_ff < s2_row_ff)              code = SPR_FILL;
            else if (s2_col_ff <= s2_row_ff + 5'd2)      code = SPR_BLACK;
            else                                         code = SPR_CLEAR;
         end
      endcase

      hit = s2_box_ff && (code != SPR_CLEAR);
      merged_idx = s2_idx_ff;
      if (hit) begin
         unique case (code)
            SPR_BLACK: merged_idx = SprIdxBlack;
            SPR_FILL:  merged_idx = SprIdxFill;
            SPR_EDGE:  merged_idx = SprIdxEdge;
            default:   merged_idx = s2_idx_ff;
         endcase
      end
   end

   logic [IDXW-1:0] s3_idx_ff;
   logic            s3_hit_ff;

   always_ff @(posedge clock) begin
      if (s3_load) begin
         s3_idx_ff <= merged_idx;
         s3_hit_ff <= hit;
      end
   end

   // ------------------------------------------- stage 4: palette and format
   logic [31:0] argb, pixel_value;

   always_comb begin
      argb = palette_lookup(s3_idx_ff);
      unique case (pixel_format_ff)
         FMT_INDEX: pixel_value = {28'd0, s3_idx_ff};
         FMT_RGB:   pixel_value = {8'd0, argb[23:0]};
         default:   pixel_value = argb;
      endcase
   end

   logic [31:0] s4_value_ff;
   logic        s4_hit_ff;

   always_ff @(posedge clock) begin
      if (s4_load) begin
         s4_value_ff <= pixel_value;
         s4_hit_ff   <= s3_hit_ff;
      end
   end

   assign rsp_tvalid   = s4_valid_ff;
   assign rsp_tdata    = s4_value_ff;
   assign rsp_tuser[0] = s4_hit_ff;

   // ------------------------------------------------------------- assertions
   `CSOP_ASSERT(a_accept_fills_s1, (req_tvalid && req_tready) |=> s1_valid_ff,
      "accepted request did not reach stage 1")
   `CSOP_ASSERT(a_hit_index, (s3_valid_ff && s3_hit_ff) |->
      (s3_idx_ff == SprIdxBlack || s3_idx_ff == SprIdxFill || s3_idx_ff == SprIdxEdge),
      "cursor hit carries a non-sprite index")
   `CSOP_ASSERT_ALWAYS(a_stall_only_full, !req_tready |->
      (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && !rsp_tready),
      "request stalled with an empty stage")

endmodule
